// ===== src/scfe_pkg.sv =====
`timescale 1ns / 1ps
package scfe_pkg;

   // Operation codes of an input transfer.
   localparam logic [2:0] OP_SEL_FALL  = 3'd0;
   localparam logic [2:0] OP_RX_BYTE   = 3'd1;
   localparam logic [2:0] OP_SEL_RISE  = 3'd2;
   localparam logic [2:0] OP_TX_REQ    = 3'd3;
   localparam logic [2:0] OP_RPL_BEGIN = 3'd4;
   localparam logic [2:0] OP_RPL_BYTE  = 3'd5;
   localparam logic [2:0] OP_PAY_READ  = 3'd6;

   // Result kinds.
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_VALID   = 2'd1;
   localparam logic [1:0] KIND_TX      = 2'd2;
   localparam logic [1:0] KIND_PAYLOAD = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START    = 2'd0;
   localparam logic [1:0] CSR_IOERR    = 2'd1;
   localparam logic [1:0] CSR_SEQ_EN   = 2'd2;
   localparam logic [1:0] CSR_REW_BND  = 2'd3;

   // One CRC-16/CCITT-FALSE byte update, eight narrow shift steps.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== src/scfe_ram.sv =====
`timescale 1ns / 1ps
// Single-port-write, single-port-read byte store with registered read data.
module scfe_ram #(
   parameter int AW = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [0:(1<<AW)-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/sof_crc_frame_slave_endpoint_top.sv =====
`timescale 1ns / 1ps
// Channel | Handshake        | Contents
// req     | tvalid / tready  | tuser: operation; tlast: reply_last;
//         |                  | tdata: data_byte, reply_status, byte_index
// rsp     | tvalid / tready  | tuser: result_kind; tdata: command_code, payload_length,
//         |                  | out_byte, transmit_pending, error_staged, cursor_rewound
// csr     | csr_wr_en        | csr_index, csr_data
// One transfer is handled at a time by a sequencer around two byte memories.
// Acknowledge-only operations go from DISP to OUT; transmit and payload reads pass
// through TXRD or PAYRD; a reply begin passes through PUT1 and CMDRD (and CLOSE1 and
// CLOSE2 when it also closes the reply); a closing reply byte through CLOSE1 and CLOSE2.
// A select rise walks the request one byte a cycle and may then stage an error reply.
// Reset clears the sequencer state, counters and output valid; memory contents are undefined until written.
// A finished result waits in the output register; the sequencer only stalls in its
// last step while that register still holds an untaken result.
module sof_crc_frame_slave_endpoint_top #(
   parameter int MAX_PAYLOAD = 60,
   parameter int FRAME_BYTES = 64,
   parameter int STAMP_SHIFT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] operation
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,
   // [7:0] data_byte, [15:8] reply_status, [21:16] byte_index, [23:22] zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] result_kind
   output logic [1:0]  rsp_tuser,
   // [7:0] command_code, [13:8] payload_length, [21:14] out_byte,
   // [22] transmit_pending, [23] error_staged, [24] cursor_rewound, [31:25] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   localparam int AW = (FRAME_BYTES > MAX_PAYLOAD + 4) ? $clog2(FRAME_BYTES) :
                       $clog2(MAX_PAYLOAD + 4);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] FRAME_LIM = CW'(FRAME_BYTES);
   localparam logic [CW-1:0] FILL_LIM  = CW'(MAX_PAYLOAD + 2);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_WALK   = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_PUT1   = 4'd4;
   localparam logic [3:0] S_CLOSE1 = 4'd5;
   localparam logic [3:0] S_CLOSE2 = 4'd6;
   localparam logic [3:0] S_TXRD   = 4'd7;
   localparam logic [3:0] S_PAYRD  = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;
   localparam logic [3:0] S_CMDRD  = 4'd10;

   // Configuration registers.
   logic [7:0] start_ff;
   logic [3:0] ioerr_ff;
   logic       seq_en_ff;
   logic [7:0] rew_bnd_ff;

   // Control state.
   logic [3:0]    state_ff;
   logic [2:0]    op_ff;
   logic [7:0]    data_ff, rstat_ff;
   logic          last_ff;
   logic [5:0]    idx_ff;
   logic [CW-1:0] req_cnt_ff, rpl_cnt_ff, cursor_ff, fill_ff, walk_ff;
   logic [7:0]    streak_ff;
   logic [3:0]    stamp_ff;
   logic [15:0]   acc_ff, wcrc_ff;
   logic          open_ff;
   logic          nz_ff, first_ok_ff;
   logic [7:0]    got_lo_ff, got_hi_ff;
   logic          after_close_ff;
   logic [1:0]    kind_ff;
   logic [7:0]    cmd_ff, obyte_ff;
   logic [5:0]    plen_ff;
   logic          err_ff, rew_ff;
   logic          out_v_ff;
   logic [24:0]   rsp_data_ff;
   logic [1:0]    rsp_kind_ff;

   // Memory ports.
   logic          qwe, rwe;
   logic [AW-1:0] qwa, qra, rwa, rra;
   logic [7:0]    qwd, qrd, rwd, rrd;

   scfe_ram #(.AW(AW)) u_req_mem (
      .clock(clock), .wr_en(qwe), .wr_addr(qwa), .wr_data(qwd),
      .rd_addr(qra), .rd_data(qrd)
   );
   scfe_ram #(.AW(AW)) u_rpl_mem (
      .clock(clock), .wr_en(rwe), .wr_addr(rwa), .wr_data(rwd),
      .rd_addr(rra), .rd_data(rrd)
   );

   wire [2:0] in_op = req_tuser;
   assign req_tready = (state_ff == S_IDLE);
   wire acc_in = req_tvalid && req_tready;
   wire out_load = (state_ff == S_OUT) && (!out_v_ff || rsp_tready);

   // Stamped status for a freshly opened reply.
   wire [3:0] stamp_next = stamp_ff + 4'd1;
   function automatic logic [7:0] stamped(input logic [7:0] s, input logic en,
                                          input logic [3:0] st);
      logic [11:0] sh;
      sh = {8'h00, st} << STAMP_SHIFT;
      return en ? (s | sh[7:0]) : s;
   endfunction

   // Memory address and write control.
   always_comb begin
      qwe = acc_in && in_op == scfe_pkg::OP_RX_BYTE && req_cnt_ff < FRAME_LIM;
      qwa = req_cnt_ff[AW-1:0];
      qwd = req_tdata[7:0];
      qra = walk_ff[AW-1:0];
      rwe = 1'b0;
      rwa = fill_ff[AW-1:0];
      rwd = data_ff;
      rra = cursor_ff[AW-1:0];
      case (state_ff)
         S_PUT1: begin
            rwe = 1'b1;
         end
         S_CMDRD: begin
            rwe = 1'b1;
         end
         S_CLOSE1: begin
            rwe = 1'b1;
            rwd = acc_ff[7:0];
         end
         S_CLOSE2: begin
            rwe = 1'b1;
            rwd = acc_ff[15:8];
         end
         S_DISP: begin
            if (op_ff == scfe_pkg::OP_RPL_BYTE && open_ff && fill_ff < FILL_LIM) begin
               rwe = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   wire [CW-1:0] n_crc = req_cnt_ff - CW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 8'd165; ioerr_ff <= 4'd1; seq_en_ff <= 1'b0; rew_bnd_ff <= 8'd12;
         state_ff <= S_IDLE; out_v_ff <= 1'b0;
         req_cnt_ff <= '0; rpl_cnt_ff <= '0; cursor_ff <= '0; fill_ff <= '0;
         streak_ff <= '0; stamp_ff <= '0; acc_ff <= 16'hFFFF; open_ff <= 1'b0;
         after_close_ff <= 1'b0; walk_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               scfe_pkg::CSR_START:   start_ff   <= csr_data;
               scfe_pkg::CSR_IOERR:   ioerr_ff   <= csr_data[3:0];
               scfe_pkg::CSR_SEQ_EN:  seq_en_ff  <= csr_data[0];
               scfe_pkg::CSR_REW_BND: rew_bnd_ff <= csr_data;
               default: begin
               end
            endcase
         end
         // Output register: loaded at the end of an item, held until taken.
         if (out_load) begin
            out_v_ff <= 1'b1;
            rsp_kind_ff <= kind_ff;
            rsp_data_ff <= {rew_ff, err_ff, (cursor_ff < rpl_cnt_ff), obyte_ff,
                            plen_ff, cmd_ff};
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (acc_in) begin
                  op_ff <= in_op;
                  data_ff <= req_tdata[7:0];
                  rstat_ff <= req_tdata[15:8];
                  last_ff <= req_tlast;
                  idx_ff <= req_tdata[21:16];
                  kind_ff <= scfe_pkg::KIND_ACK;
                  cmd_ff <= '0; plen_ff <= '0; obyte_ff <= '0;
                  err_ff <= 1'b0; rew_ff <= 1'b0;
                  // A payload read presents its address during DISP.
                  walk_ff <= (in_op == scfe_pkg::OP_PAY_READ) ?
                             CW'(req_tdata[21:16]) + CW'(2) : '0;
                  if (in_op == scfe_pkg::OP_RX_BYTE && req_cnt_ff < FRAME_LIM) begin
                     req_cnt_ff <= req_cnt_ff + CW'(1);
                  end
                  if (in_op == scfe_pkg::OP_SEL_FALL) begin
                     req_cnt_ff <= '0;
                  end
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               case (op_ff)
                  scfe_pkg::OP_SEL_RISE: begin
                     nz_ff <= 1'b0; first_ok_ff <= 1'b0; wcrc_ff <= 16'hFFFF;
                     if (req_cnt_ff == '0) begin
                        state_ff <= S_CHECK;
                     end else begin
                        walk_ff <= CW'(1);
                        state_ff <= S_WALK;
                     end
                  end
                  scfe_pkg::OP_TX_REQ: begin
                     kind_ff <= scfe_pkg::KIND_TX;
                     state_ff <= S_TXRD;
                  end
                  scfe_pkg::OP_RPL_BEGIN: begin
                     if (seq_en_ff) stamp_ff <= stamp_next;
                     data_ff <= stamped(rstat_ff, seq_en_ff, stamp_next);
                     fill_ff <= CW'(1);
                     acc_ff <= scfe_pkg::crc_feed(16'hFFFF, start_ff);
                     rpl_cnt_ff <= '0; cursor_ff <= '0; streak_ff <= '0; open_ff <= 1'b1;
                     after_close_ff <= last_ff;
                     state_ff <= S_PUT1;
                  end
                  scfe_pkg::OP_RPL_BYTE: begin
                     if (open_ff && fill_ff < FILL_LIM) begin
                        fill_ff <= fill_ff + CW'(1);
                        acc_ff <= scfe_pkg::crc_feed(acc_ff, data_ff);
                     end
                     state_ff <= (open_ff && last_ff) ? S_CLOSE1 : S_OUT;
                  end
                  scfe_pkg::OP_PAY_READ: begin
                     kind_ff <= scfe_pkg::KIND_PAYLOAD;
                     state_ff <= S_PAYRD;
                  end
                  default: begin
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_PUT1: begin
               // Status byte goes to fill 1; start byte is written next.
               acc_ff <= scfe_pkg::crc_feed(acc_ff, data_ff);
               fill_ff <= CW'(0);
               data_ff <= start_ff;
               state_ff <= S_CMDRD;
            end
            S_CMDRD: begin
               // Start byte written at fill 0 this cycle.
               fill_ff <= CW'(2);
               state_ff <= after_close_ff ? S_CLOSE1 : S_OUT;
            end
            S_WALK: begin
               // qrd holds byte walk-1.
               if (qrd != 8'd0) nz_ff <= 1'b1;
               if (walk_ff == CW'(1)) first_ok_ff <= (qrd == start_ff);
               if (walk_ff <= n_crc) wcrc_ff <= scfe_pkg::crc_feed(wcrc_ff, qrd);
               if (walk_ff == CW'(2)) cmd_ff <= qrd;
               if (walk_ff == n_crc + CW'(1)) got_lo_ff <= qrd;
               if (walk_ff == n_crc + CW'(2)) got_hi_ff <= qrd;
               if (walk_ff == req_cnt_ff) begin
                  state_ff <= S_CHECK;
               end else begin
                  walk_ff <= walk_ff + CW'(1);
               end
            end
            S_CHECK: begin
               if (req_cnt_ff == '0 || (!first_ok_ff && !nz_ff)) begin
                  // Empty or all-zero transaction: rewind unless the streak is too long.
                  streak_ff <= streak_ff + 8'd1;
                  cmd_ff <= '0;
                  if (streak_ff + 8'd1 > rew_bnd_ff) begin
                     err_ff <= 1'b1;
                     rstat_ff <= {4'd0, ioerr_ff};
                     op_ff <= scfe_pkg::OP_RPL_BEGIN; last_ff <= 1'b1;
                     state_ff <= S_DISP;
                  end else begin
                     rew_ff <= 1'b1;
                     cursor_ff <= '0;
                     state_ff <= S_OUT;
                  end
               end else if (!first_ok_ff || req_cnt_ff < CW'(4) ||
                            wcrc_ff != {got_hi_ff, got_lo_ff}) begin
                  // Framing or CRC failure stages an error reply.
                  err_ff <= 1'b1;
                  cmd_ff <= '0;
                  rstat_ff <= {4'd0, ioerr_ff};
                  op_ff <= scfe_pkg::OP_RPL_BEGIN; last_ff <= 1'b1;
                  state_ff <= S_DISP;
               end else begin
                  kind_ff <= scfe_pkg::KIND_VALID;
                  plen_ff <= 6'(req_cnt_ff - CW'(4));
                  state_ff <= S_OUT;
               end
            end
            S_CLOSE1: begin
               fill_ff <= fill_ff + CW'(1);
               state_ff <= S_CLOSE2;
            end
            S_CLOSE2: begin
               rpl_cnt_ff <= fill_ff + CW'(1);
               cursor_ff <= '0; open_ff <= 1'b0;
               state_ff <= S_OUT;
            end
            S_TXRD: begin
               state_ff <= S_OUT;
               if (cursor_ff < rpl_cnt_ff) begin
                  obyte_ff <= rrd;
                  cursor_ff <= cursor_ff + CW'(1);
               end else begin
                  obyte_ff <= 8'hFF;
               end
            end
            S_PAYRD: begin
               state_ff <= S_OUT;
               if (req_cnt_ff >= CW'(4) && CW'(idx_ff) < req_cnt_ff - CW'(4)) begin
                  obyte_ff <= qrd;
               end
            end
            S_OUT: begin
               if (out_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // TXRD and PAYRD both present their read address during DISP.
   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tdata = {7'd0, rsp_data_ff};

   // A held result does not change until taken.
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("held result changed");
   // A select rise never both rewinds and stages an error.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[23] && rsp_tdata[24])) else $error("rewind and error together");
   // A result stays held until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
endmodule

// ===== test/scfe_checker.sv =====
`timescale 1ns / 1ps
module scfe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [1:0]  rsp_tuser,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic       rewound;
      logic       err_staged;
      logic       more_tx;
      logic [7:0] obyte;
      logic [5:0] plen;
      logic [7:0] cmd;
      logic [1:0] kind;
   } answer_type;

   // Predicted endpoint state.
   logic [7:0]  rq_mem [64];
   int          rq_cnt;
   logic [7:0]  tx_mem [256];
   int          tx_len;
   int          tx_pos;
   int          build_fill;
   bit          build_open;
   logic [7:0]  streak;
   logic [3:0]  stamp;
   logic [15:0] build_crc;

   // Shadow registers.
   logic [7:0]  sof_val;
   logic [3:0]  ioerr_val;
   logic        seq_on;
   logic [7:0]  rew_limit;

   answer_type answers_due[$];

   // CRC-16/CCITT-FALSE, one bit at a time, MSB first.
   function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0};
         if (fb) c = c ^ 16'h1021;
      end
      return c;
   endfunction

   function automatic void put_reply(logic [7:0] b);
      tx_mem[build_fill[7:0]] = b;
      build_fill++;
      build_crc = crc_byte(build_crc, b);
   endfunction

   function automatic void begin_reply(logic [7:0] st);
      if (seq_on) begin
         stamp = stamp + 4'd1;
         st = st | (8'(stamp) << 4);
      end
      build_fill = 0;
      build_crc = 16'hFFFF;
      put_reply(sof_val);
      put_reply(st);
      tx_len = 0;
      tx_pos = 0;
      streak = 0;
      build_open = 1;
   endfunction

   function automatic void end_reply();
      tx_mem[build_fill[7:0]] = build_crc[7:0];
      tx_mem[8'(build_fill + 1)] = build_crc[15:8];
      tx_len = build_fill + 2;
      tx_pos = 0;
      build_open = 0;
   endfunction

   function automatic void error_reply();
      begin_reply({4'd0, ioerr_val});
      end_reply();
   endfunction

   // Returns one when the streak forced an error reply.
   function automatic bit rewind_step();
      streak = streak + 8'd1;
      if (streak > rew_limit) begin
         error_reply();
         return 1;
      end
      tx_pos = 0;
      return 0;
   endfunction

   function automatic answer_type predict_transfer(logic [31:0] d);
      answer_type a;
      logic [2:0]  op;
      logic [7:0]  dbyte;
      logic [7:0]  st;
      logic        lst;
      logic [5:0]  idx;
      bit          all_zero;
      logic [15:0] c;
      logic [15:0] got;
      int          n;
      op = d[2:0];
      dbyte = d[10:3];
      st = d[18:11];
      lst = d[19];
      idx = d[25:20];
      a = '0;
      case (op)
         scfe_pkg::OP_SEL_FALL: rq_cnt = 0;
         scfe_pkg::OP_RX_BYTE: begin
            if (rq_cnt < 64) begin
               rq_mem[rq_cnt] = dbyte;
               rq_cnt++;
            end
         end
         scfe_pkg::OP_SEL_RISE: begin
            if (rq_cnt == 0) begin
               if (rewind_step()) a.err_staged = 1; else a.rewound = 1;
            end else if (rq_mem[0] != sof_val) begin
               all_zero = 1;
               for (int i = 0; i < rq_cnt; i++) if (rq_mem[i] != 0) all_zero = 0;
               if (!all_zero) begin
                  error_reply();
                  a.err_staged = 1;
               end else if (rewind_step()) begin
                  a.err_staged = 1;
               end else begin
                  a.rewound = 1;
               end
            end else if (rq_cnt < 4) begin
               error_reply();
               a.err_staged = 1;
            end else begin
               n = rq_cnt - 2;
               c = 16'hFFFF;
               for (int i = 0; i < n; i++) c = crc_byte(c, rq_mem[i]);
               got = {rq_mem[n + 1], rq_mem[n]};
               if (c != got) begin
                  error_reply();
                  a.err_staged = 1;
               end else begin
                  a.kind = scfe_pkg::KIND_VALID;
                  a.cmd = rq_mem[1];
                  a.plen = 6'(rq_cnt - 4);
               end
            end
         end
         scfe_pkg::OP_TX_REQ: begin
            a.kind = scfe_pkg::KIND_TX;
            if (tx_pos < tx_len) begin
               a.obyte = tx_mem[tx_pos[7:0]];
               tx_pos++;
            end else begin
               a.obyte = 8'hFF;
            end
         end
         scfe_pkg::OP_RPL_BEGIN: begin
            begin_reply(st);
            if (lst) end_reply();
         end
         scfe_pkg::OP_RPL_BYTE: begin
            if (build_open) begin
               if (build_fill < 62) put_reply(dbyte);
               if (lst) end_reply();
            end
         end
         scfe_pkg::OP_PAY_READ: begin
            a.kind = scfe_pkg::KIND_PAYLOAD;
            if (rq_cnt >= 4 && int'(idx) < rq_cnt - 4) a.obyte = rq_mem[2 + idx];
         end
         default: ;
      endcase
      a.more_tx = (tx_pos < tx_len);
      return a;
   endfunction

   task automatic check_field(string name, int want, int seen);
      if (want != seen) begin
         $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h", $time, name, want, seen);
         fail_count++;
      end
   endtask

   // Apply register writes, predict each accepted request, compare each result.
   always @(posedge clock) begin
      answer_type want;
      answer_type seen;
      logic [31:0] item;
      if (reset) begin
         rq_cnt = 0;
         tx_len = 0;
         tx_pos = 0;
         build_fill = 0;
         build_open = 0;
         streak = 0;
         stamp = 0;
         build_crc = 16'hFFFF;
         sof_val = 8'hA5;
         ioerr_val = 4'd1;
         seq_on = 0;
         rew_limit = 8'd12;
         answers_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               scfe_pkg::CSR_START:   sof_val = csr_data;
               scfe_pkg::CSR_IOERR:   ioerr_val = csr_data[3:0];
               scfe_pkg::CSR_SEQ_EN:  seq_on = csr_data[0];
               scfe_pkg::CSR_REW_BND: rew_limit = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            item = {6'd0, req_tdata[21:16], req_tlast, req_tdata[15:8], req_tdata[7:0],
                    req_tuser};
            answers_due.push_back(predict_transfer(item));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.kind = rsp_tuser;
            seen.cmd = rsp_tdata[7:0];
            seen.plen = rsp_tdata[13:8];
            seen.obyte = rsp_tdata[21:14];
            seen.more_tx = rsp_tdata[22];
            seen.err_staged = rsp_tdata[23];
            seen.rewound = rsp_tdata[24];
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual 0x%0h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               check_field("result_kind", want.kind, seen.kind);
               check_field("command_code", want.cmd, seen.cmd);
               check_field("payload_length", want.plen, seen.plen);
               check_field("out_byte", want.obyte, seen.obyte);
               check_field("transmit_pending", want.more_tx, seen.more_tx);
               check_field("error_staged", want.err_staged, seen.err_staged);
               check_field("cursor_rewound", want.rewound, seen.rewound);
               check_field("pad bits", 0, int'(rsp_tdata[31:25]));
            end
         end
      end
      outstanding <= answers_due.size();
   end

   initial begin
      fail_count = 0;
      outstanding = 0;
      rq_cnt = 0;
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [2:0]  req_tuser;
   logic        req_tlast;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;
   int          fail_count;
   int          outstanding;

   int          sent_count;
   int          burst_left;
   logic [7:0]  cur_sof;
   bit          stim_done;
   int          idle_cycles;

   sof_crc_frame_slave_endpoint_top u_top (.*);

   scfe_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tlast(req_tlast), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] pack(logic [2:0] op, logic [7:0] dbyte, logic [7:0] st,
                                        logic lst, logic [5:0] idx);
      return {6'd0, idx, lst, st, dbyte, op};
   endfunction

   // Offer one transfer; the sender runs in bursts separated by random gaps.
   task automatic push_transfer(logic [31:0] d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock) req_tvalid <= 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1;
      req_tuser <= d[2:0];
      req_tlast <= d[19];
      req_tdata <= {2'd0, d[25:20], d[18:11], d[10:3]};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic push_op(logic [2:0] op);
      push_transfer(pack(op, 8'($urandom), 8'($urandom), 1'($urandom), 6'($urandom)));
   endtask

   // Send one request frame: select fall, bytes, select rise.
   task automatic send_frame(logic [7:0] cmd, int plen, bit corrupt);
      logic [7:0]  fb[$];
      logic [15:0] c;
      int          k;
      fb.push_back(cur_sof);
      fb.push_back(cmd);
      for (int i = 0; i < plen; i++) fb.push_back(8'($urandom));
      c = 16'hFFFF;
      foreach (fb[i]) c = scfe_pkg::crc_feed(c, fb[i]);
      fb.push_back(c[7:0]);
      fb.push_back(c[15:8]);
      if (corrupt) begin
         k = $urandom_range(0, fb.size() - 1);
         fb[k] = fb[k] ^ 8'(8'd1 << $urandom_range(0, 7));
      end
      push_op(scfe_pkg::OP_SEL_FALL);
      foreach (fb[i])
         push_transfer(pack(scfe_pkg::OP_RX_BYTE, fb[i], 8'($urandom), 1'($urandom),
                            6'($urandom)));
      push_op(scfe_pkg::OP_SEL_RISE);
   endtask

   // Build a reply of n payload bytes, then issue the given number of transmit requests.
   task automatic serve_reply(int n, int reads);
      push_transfer(pack(scfe_pkg::OP_RPL_BEGIN, 8'($urandom), 8'($urandom), n == 0,
                         6'($urandom)));
      for (int i = 0; i < n; i++)
         push_transfer(pack(scfe_pkg::OP_RPL_BYTE, 8'($urandom), 8'($urandom), i == n - 1,
                            6'($urandom)));
      repeat (reads) push_op(scfe_pkg::OP_TX_REQ);
   endtask

   // Stop offering, wait for every result, let the sequencer settle.
   task automatic drain();
      @(negedge clock) req_tvalid <= 0;
      burst_left = 0;
      while (outstanding != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_settings(logic [7:0] sof, logic [3:0] ioerr, logic seq,
                                 logic [7:0] bound);
      drain();
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= scfe_pkg::CSR_START;
      csr_data <= sof;
      @(negedge clock);
      csr_index <= scfe_pkg::CSR_IOERR;
      csr_data <= {4'd0, ioerr};
      @(negedge clock);
      csr_index <= scfe_pkg::CSR_SEQ_EN;
      csr_data <= {7'd0, seq};
      @(negedge clock);
      csr_index <= scfe_pkg::CSR_REW_BND;
      csr_data <= bound;
      @(negedge clock);
      csr_wr_en <= 0;
      cur_sof = sof;
   endtask

   task automatic random_transaction();
      int pick;
      int plen;
      pick = $urandom_range(0, 11);
      if (pick <= 5) begin
         plen = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 6);
         send_frame(8'($urandom), plen, $urandom_range(0, 5) == 0);
         repeat ($urandom_range(0, 2))
            push_transfer(pack(scfe_pkg::OP_PAY_READ, 8'($urandom), 8'($urandom),
                               1'($urandom), 6'($urandom_range(0, plen + 1))));
         plen = ($urandom_range(0, 20) == 0) ? $urandom_range(58, 64) : $urandom_range(0, 5);
         serve_reply(plen, $urandom_range(0, plen + 5));
      end else if (pick == 6) begin
         // Empty transaction, possibly with zero bytes clocked in.
         push_op(scfe_pkg::OP_SEL_FALL);
         repeat ($urandom_range(0, 2))
            push_transfer(pack(scfe_pkg::OP_RX_BYTE, 8'd0, 8'($urandom), 1'($urandom),
                               6'($urandom)));
         push_op(scfe_pkg::OP_SEL_RISE);
         repeat ($urandom_range(0, 3)) push_op(scfe_pkg::OP_TX_REQ);
      end else if (pick == 7) begin
         repeat ($urandom_range(1, 6)) push_transfer($urandom & 32'h03FF_FFFF);
      end else if (pick == 8) begin
         // Overlong or framing-broken request.
         push_op(scfe_pkg::OP_SEL_FALL);
         push_transfer(pack(scfe_pkg::OP_RX_BYTE,
                            ($urandom_range(0, 1) != 0) ? cur_sof : 8'($urandom),
                            8'd0, 1'b0, 6'd0));
         repeat ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(62, 68))
            push_op(scfe_pkg::OP_RX_BYTE);
         push_op(scfe_pkg::OP_SEL_RISE);
      end else if (pick == 9) begin
         repeat ($urandom_range(1, 5)) push_op(scfe_pkg::OP_SEL_RISE);
      end else begin
         repeat ($urandom_range(1, 4))
            push_op(($urandom_range(0, 1) != 0) ? scfe_pkg::OP_TX_REQ : scfe_pkg::OP_PAY_READ);
      end
   endtask

   // Receiver: random ready patterns, and one long hold-off while traffic continues.
   initial begin
      int mode;
      int len;
      bit held;
      held = 0;
      rsp_tready = 0;
      @(negedge clock);
      while (!stim_done) begin
         if (!held && sent_count > 400) begin
            held = 1;
            for (int i = 0; i < 300; i++) @(negedge clock) rsp_tready <= 0;
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(5, 60);
         for (int i = 0; i < len; i++) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (i % 7) < 5;
            endcase
         end
      end
      @(negedge clock) rsp_tready <= 1;
   end

   // Watchdog: cycles without any transfer or register write.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int waited;
      reset = 1;
      req_tvalid = 0;
      req_tuser = '0;
      req_tlast = 0;
      req_tdata = '0;
      csr_wr_en = 0;
      csr_index = scfe_pkg::CSR_START;
      csr_data = '0;
      sent_count = 0;
      burst_left = 0;
      stim_done = 0;
      idle_cycles = 0;
      cur_sof = 8'hA5;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 0;

      // Directed: empty rise, drain with nothing staged, unused op, stray reply byte.
      push_op(scfe_pkg::OP_SEL_FALL);
      push_op(scfe_pkg::OP_SEL_RISE);
      push_op(scfe_pkg::OP_TX_REQ);
      push_transfer(pack(3'd7, 8'hFF, 8'hFF, 1'b1, 6'h3F));
      push_transfer(pack(scfe_pkg::OP_RPL_BYTE, 8'h00, 8'h00, 1'b1, 6'h00));
      // Valid frame, payload reads in and out of range, empty reply.
      send_frame(8'hFF, 1, 0);
      push_transfer(pack(scfe_pkg::OP_PAY_READ, 8'd0, 8'd0, 1'b0, 6'd0));
      push_transfer(pack(scfe_pkg::OP_PAY_READ, 8'd0, 8'd0, 1'b0, 6'h3F));
      push_transfer(pack(scfe_pkg::OP_RPL_BEGIN, 8'd0, 8'hFF, 1'b1, 6'd0));
      repeat (5) push_op(scfe_pkg::OP_TX_REQ);
      // Too short, and non-zero without start byte.
      push_op(scfe_pkg::OP_SEL_FALL);
      push_transfer(pack(scfe_pkg::OP_RX_BYTE, cur_sof, 8'd0, 1'b0, 6'd0));
      push_op(scfe_pkg::OP_SEL_RISE);
      push_op(scfe_pkg::OP_SEL_FALL);
      push_transfer(pack(scfe_pkg::OP_RX_BYTE, 8'h01, 8'd0, 1'b0, 6'd0));
      push_op(scfe_pkg::OP_SEL_RISE);
      // Bad CRC.
      send_frame(8'h00, 0, 1);

      write_settings(8'h00, 4'hF, 1, 8'd0);
      // All-zero frame counted as framed when the start byte is zero.
      push_op(scfe_pkg::OP_SEL_FALL);
      repeat (4) push_transfer(pack(scfe_pkg::OP_RX_BYTE, 8'd0, 8'd0, 1'b0, 6'd0));
      push_op(scfe_pkg::OP_SEL_RISE);
      repeat (3) push_op(scfe_pkg::OP_SEL_RISE);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_settings(8'hA5, 4'd1, 1'b0, 8'd12);
            1: write_settings(8'h00, 4'hF, 1'b1, 8'd0);
            2: write_settings(8'hFF, 4'd0, 1'b1, 8'd255);
            default: write_settings(8'($urandom), 4'($urandom), 1'b1,
                                    8'($urandom_range(0, 4)));
         endcase
         while (sent_count < 270 * (ph + 1) + 60) random_transaction();
      end
      @(negedge clock) req_tvalid <= 0;
      stim_done = 1;

      waited = 0;
      while (outstanding != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
